/* rtl/ptpc_pkg.sv */
// Shared types, codes and constants for the precision time clock block.
// Used by the channel interfaces and every module of the block; depends on nothing.
`timescale 1ns / 1ps

package ptpc_pkg;

    // Default values of the top-level parameters.
    localparam int PPB_FRACTION_BITS_DEF = 16;
    localparam int ELAPSED_WIDTH_DEF     = 32;

    // Field widths of the channels.
    localparam int MODE_W      = 2;
    localparam int TICK_NS_W   = 32;
    localparam int OFFSET_W    = 48;
    localparam int FREQ_W      = 48;
    localparam int EFF_W       = 49;
    localparam int TIME_W      = 64;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 48;

    // Operation codes carried in the mode field.
    localparam logic [MODE_W-1:0] MODE_TICK     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ADJ_TIME = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ADJ_FREQ = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RESET    = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_ENABLED    = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BASE_DRIFT = 1'd1;

    // Depth of the queue between front and back.
    localparam int QUEUE_DEPTH = 4;

    // Quotient bits resolved per stage of the divide-by-one-billion pipeline.
    localparam int DIV_BITS_PER_STAGE = 4;

    // Saturation limits of the frequency correction.
    localparam logic signed [FREQ_W-1:0] FREQ_MAX = {1'b0, {(FREQ_W-1){1'b1}}};
    localparam logic signed [FREQ_W-1:0] FREQ_MIN = {1'b1, {(FREQ_W-1){1'b0}}};

    // Work the back end has to do for one item.
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_TICK,
        OP_STEP,
        OP_SLEW,
        OP_CLEAR
    } t_op;

    // Queue entry: classified item with the frequency correction after it.
    typedef struct packed {
        t_op                        op;
        logic [TICK_NS_W-1:0]       elapsed;
        logic signed [OFFSET_W-1:0] offset;
        logic signed [FREQ_W-1:0]   freq;
    } t_entry;

    // Job carried alongside the scaling pipeline.
    typedef struct packed {
        t_op                        op;
        logic signed [OFFSET_W-1:0] offset;
        logic signed [EFF_W-1:0]    eff;
    } t_job;

endpackage

/* rtl/ptpc_intf.sv */
// Valid/ready channel interfaces of the precision time clock block.
// Depends on ptpc_pkg for the field widths.
`timescale 1ns / 1ps

// Input item channel.
interface ptpc_in_if;
    logic                                      valid;
    logic                                      ready;
    logic [ptpc_pkg::MODE_W-1:0]               mode;
    logic [ptpc_pkg::TICK_NS_W-1:0]            tick_ns;
    logic signed [ptpc_pkg::OFFSET_W-1:0]      step_ns;
    logic signed [ptpc_pkg::FREQ_W-1:0]        freq_step_q16;

    modport source (output valid, mode, tick_ns, step_ns, freq_step_q16, input ready);
    modport sink   (input valid, mode, tick_ns, step_ns, freq_step_q16, output ready);
endinterface

// Result channel.
interface ptpc_out_if;
    logic                                      valid;
    logic                                      ready;
    logic [ptpc_pkg::TIME_W-1:0]               time_ns;
    logic [ptpc_pkg::TIME_W-1:0]               ticks_seen;
    logic signed [ptpc_pkg::TIME_W-1:0]        total_offset_ns;
    logic signed [ptpc_pkg::EFF_W-1:0]         effective_drift_q16;

    modport source (output valid, time_ns, ticks_seen, total_offset_ns, effective_drift_q16,
                    input ready);
    modport sink   (input valid, time_ns, ticks_seen, total_offset_ns, effective_drift_q16,
                    output ready);
endinterface

// Configuration write channel.
interface ptpc_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [ptpc_pkg::CFG_INDEX_W-1:0]    index;
    logic [ptpc_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/ptp_clock_with_drift_adjust.sv */
// Precision time clock with step and frequency correction; one item per cycle if unstalled.
// Depends on ptpc_pkg, ptpc_intf.sv, ptpc_front, ptpc_queue and ptpc_back.
`timescale 1ns / 1ps

// The block takes one operation (tick, time step, frequency step or reset) per cycle
// and returns one result per operation, in order, at a sustained rate of one item per
// clock while the result side is not stalled. Each item passes through the two-part
// multiplier and the pipelined divide by one billion, which resolves four quotient bits
// per stage. A four-entry queue behind the input lets items keep arriving while the
// result side is stalled. Configuration writes are taken in any cycle but must only be
// issued while no item is in flight.
module ptp_clock_with_drift_adjust #(
    parameter int PPB_FRACTION_BITS = ptpc_pkg::PPB_FRACTION_BITS_DEF,
    parameter int ELAPSED_WIDTH     = ptpc_pkg::ELAPSED_WIDTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    ptpc_in_if.sink         i_item,
    ptpc_cfg_if.sink        i_cfg,
    ptpc_out_if.source      o_res
);

    logic                                  push;
    ptpc_pkg::t_entry                      push_entry;
    logic                                  q_ready;
    logic                                  q_valid;
    ptpc_pkg::t_entry                      q_entry;
    logic                                  pop;
    logic signed [ptpc_pkg::FREQ_W-1:0]    base_drift;

    ptpc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (i_item),
        .i_cfg        (i_cfg),
        .i_q_ready    (q_ready),
        .o_push       (push),
        .o_entry      (push_entry),
        .o_base_drift (base_drift)
    );

    ptpc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_entry (q_entry),
        .i_pop   (pop)
    );

    ptpc_back #(
        .PPB_FRACTION_BITS (PPB_FRACTION_BITS),
        .ELAPSED_WIDTH     (ELAPSED_WIDTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (q_valid),
        .i_entry      (q_entry),
        .i_base_drift (base_drift),
        .o_pop        (pop),
        .o_res        (o_res)
    );

endmodule

/* rtl/ptpc_front.sv */
// Front end: configuration registers, item classification and the frequency correction.
// Depends on ptpc_pkg and the channel interfaces in ptpc_intf.sv.
`timescale 1ns / 1ps

module ptpc_front (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    ptpc_in_if.sink                               i_item,
    ptpc_cfg_if.sink                              i_cfg,
    input  logic                                  i_q_ready,
    output logic                                  o_push,
    output ptpc_pkg::t_entry                      o_entry,
    output logic signed [ptpc_pkg::FREQ_W-1:0]    o_base_drift
);

    logic                                  r_enabled;
    logic signed [ptpc_pkg::FREQ_W-1:0]    r_base;
    logic signed [ptpc_pkg::FREQ_W-1:0]    r_freq;
    logic signed [ptpc_pkg::FREQ_W-1:0]    n_freq;
    logic signed [ptpc_pkg::FREQ_W:0]      freq_sum;
    ptpc_pkg::t_op                         op;
    logic                                  accept;

    // Configuration writes are always taken.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled <= 1'b1;
            r_base    <= '0;
        end else if (i_cfg.valid) begin
            if (i_cfg.index == ptpc_pkg::CFG_ENABLED) begin
                r_enabled <= i_cfg.data[0];
            end else begin
                r_base <= i_cfg.data;
            end
        end
    end

    // Classify the item and work out the frequency correction it leaves behind.
    assign freq_sum = $signed({i_item.freq_step_q16[ptpc_pkg::FREQ_W-1], i_item.freq_step_q16})
                    + $signed({r_freq[ptpc_pkg::FREQ_W-1], r_freq});

    always_comb begin
        n_freq = r_freq;
        op     = ptpc_pkg::OP_HOLD;
        unique case (i_item.mode)
            ptpc_pkg::MODE_RESET: begin
                op     = ptpc_pkg::OP_CLEAR;
                n_freq = '0;
            end
            ptpc_pkg::MODE_TICK: begin
                if (r_enabled) begin
                    op = ptpc_pkg::OP_TICK;
                end
            end
            ptpc_pkg::MODE_ADJ_TIME: begin
                if (r_enabled) begin
                    op = ptpc_pkg::OP_STEP;
                end
            end
            ptpc_pkg::MODE_ADJ_FREQ: begin
                if (r_enabled) begin
                    op = ptpc_pkg::OP_SLEW;
                    // Saturate when the sum leaves the 48-bit range.
                    if (freq_sum[ptpc_pkg::FREQ_W] != freq_sum[ptpc_pkg::FREQ_W-1]) begin
                        n_freq = freq_sum[ptpc_pkg::FREQ_W] ? ptpc_pkg::FREQ_MIN
                                                            : ptpc_pkg::FREQ_MAX;
                    end else begin
                        n_freq = freq_sum[ptpc_pkg::FREQ_W-1:0];
                    end
                end
            end
        endcase
    end

    assign accept       = i_item.valid && i_q_ready;
    assign i_item.ready = i_q_ready;
    assign o_push       = i_item.valid;
    assign o_base_drift = r_base;

    always_comb begin
        o_entry.op      = op;
        o_entry.elapsed = i_item.tick_ns;
        o_entry.offset  = i_item.step_ns;
        o_entry.freq    = n_freq;
    end

    // The correction advances with each accepted transaction, in item order.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq <= '0;
        end else if (accept) begin
            r_freq <= n_freq;
        end
    end

endmodule

/* rtl/ptpc_queue.sv */
// Short first-in first-out queue of classified items between front and back.
// Depends on ptpc_pkg for the entry type and depth.
`timescale 1ns / 1ps

module ptpc_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  ptpc_pkg::t_entry   i_entry,
    output logic               o_ready,
    output logic               o_valid,
    output ptpc_pkg::t_entry   o_entry,
    input  logic               i_pop
);

    localparam int DEPTH = ptpc_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    ptpc_pkg::t_entry  r_mem [0:DEPTH-1];
    logic [PTR_W-1:0]  r_wr;
    logic [PTR_W-1:0]  r_rd;
    logic [CNT_W-1:0]  r_count;
    logic              wr_en;
    logic              rd_en;

    assign o_ready = (r_count != CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd];
    assign wr_en   = i_push && o_ready;
    assign rd_en   = i_pop && o_valid;

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (wr_en) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (rd_en) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= i_entry;
        end
    end

endmodule

/* rtl/ptpc_scale.sv */
// Tick scaling pipeline: elapsed * (K + drift), shifted by the fraction bits and divided
// by one billion in a pipelined restoring divider. Depends on ptpc_pkg.
`timescale 1ns / 1ps

module ptpc_scale #(
    parameter int PPB_FRACTION_BITS = ptpc_pkg::PPB_FRACTION_BITS_DEF,
    parameter int ELAPSED_WIDTH     = ptpc_pkg::ELAPSED_WIDTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_adv,
    input  logic                                  i_valid,
    input  ptpc_pkg::t_entry                      i_entry,
    input  logic signed [ptpc_pkg::FREQ_W-1:0]    i_base_drift,
    output logic                                  o_valid,
    output ptpc_pkg::t_job                        o_job,
    output logic [ptpc_pkg::TIME_W-1:0]           o_amount
);

    localparam int EW    = ELAPSED_WIDTH;
    localparam int F     = PPB_FRACTION_BITS;
    // One second in Q.F nanoseconds.
    localparam logic [63:0] K     = 64'd1_000_000_000 << F;
    localparam logic [63:0] MSPAN = K + (64'd1 << 48);
    localparam int MW    = $clog2(MSPAN);
    localparam int ML    = (MW + 1) / 2;
    localparam int MH    = MW - ML;
    localparam int PLW   = EW + ML;
    localparam int PHW   = EW + MH;
    localparam int PW    = EW + MW;
    localparam int DW    = PW - F;
    // One billion exceeds 2^29, so the quotient has at most DW - 29 bits.
    localparam int QBITS = DW - 29;
    localparam int BPS   = ptpc_pkg::DIV_BITS_PER_STAGE;
    localparam int NS    = (QBITS + BPS - 1) / BPS;
    localparam int QPAD  = NS * BPS;
    localparam int XW    = 29 + QPAD;
    localparam int RW    = 30;
    localparam logic [RW-1:0] DIVISOR = 30'd1_000_000_000;

    // Stage 0: scale factor.
    logic signed [ptpc_pkg::EFF_W-1:0] eff;
    logic signed [64:0]                m_full;
    logic                              m_pos;
    logic                              r0_v;
    ptpc_pkg::t_job                    r0_job;
    logic [EW-1:0]                     r0_el;
    logic [MW-1:0]                     r0_m;

    // Stage 1: partial products.
    logic                              r1_v;
    ptpc_pkg::t_job                    r1_job;
    logic [PLW-1:0]                    r1_pl;
    logic [PHW-1:0]                    r1_ph;

    // Stage 2 and the divider stages.
    logic [PW-1:0]                     prod;
    logic [XW-1:0]                     x_ext;
    logic                              r_v   [0:NS];
    ptpc_pkg::t_job                    r_job [0:NS];
    logic [RW-1:0]                     r_rem [0:NS];
    logic [QPAD-1:0]                   r_low [0:NS];
    logic [RW-1:0]                     n_rem [1:NS];
    logic [QPAD-1:0]                   n_low [1:NS];
    logic [RW:0]                       t;
    logic [RW-1:0]                     rem_w;
    logic [QPAD-1:0]                   low_w;

    // Effective drift and the scale factor K + drift; a factor at or below zero counts as 0.
    assign eff    = $signed({i_base_drift[ptpc_pkg::FREQ_W-1], i_base_drift})
                  + $signed({i_entry.freq[ptpc_pkg::FREQ_W-1], i_entry.freq});
    assign m_full = $signed({1'b0, K}) + $signed({{16{eff[ptpc_pkg::EFF_W-1]}}, eff});
    assign m_pos  = !m_full[64] && (m_full != '0);

    // Full product from the two partial products.
    assign prod  = PW'(r1_pl) + (PW'(r1_ph) << ML);
    assign x_ext = XW'(prod[PW-1:F]);

    // Restoring division by one billion, BPS quotient bits per stage.
    always_comb begin
        t     = '0;
        rem_w = '0;
        low_w = '0;
        for (int d = 0; d < NS; d++) begin
            rem_w = r_rem[d];
            low_w = r_low[d];
            for (int b = 0; b < BPS; b++) begin
                t     = {rem_w, low_w[QPAD-1]};
                low_w = low_w << 1;
                if (t >= {1'b0, DIVISOR}) begin
                    t        = t - {1'b0, DIVISOR};
                    low_w[0] = 1'b1;
                end
                rem_w = t[RW-1:0];
            end
            n_rem[d+1] = rem_w;
            n_low[d+1] = low_w;
        end
    end

    // Valid bits of all stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
            r1_v <= 1'b0;
            for (int d = 0; d <= NS; d++) begin
                r_v[d] <= 1'b0;
            end
        end else if (i_adv) begin
            r0_v   <= i_valid;
            r1_v   <= r0_v;
            r_v[0] <= r1_v;
            for (int d = 0; d < NS; d++) begin
                r_v[d+1] <= r_v[d];
            end
        end
    end

    // Payload of all stages.
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r0_job.op     <= i_entry.op;
            r0_job.offset <= i_entry.offset;
            r0_job.eff    <= eff;
            r0_el         <= EW'(i_entry.elapsed);
            r0_m          <= m_pos ? m_full[MW-1:0] : '0;

            r1_job <= r0_job;
            r1_pl  <= PLW'(r0_el) * PLW'(r0_m[ML-1:0]);
            r1_ph  <= PHW'(r0_el) * PHW'(r0_m[MW-1:ML]);

            r_job[0] <= r1_job;
            r_rem[0] <= RW'(x_ext[XW-1:QPAD]);
            r_low[0] <= x_ext[QPAD-1:0];

            for (int d = 0; d < NS; d++) begin
                r_job[d+1] <= r_job[d];
                r_rem[d+1] <= n_rem[d+1];
                r_low[d+1] <= n_low[d+1];
            end
        end
    end

    assign o_valid  = r_v[NS];
    assign o_job    = r_job[NS];
    assign o_amount = ptpc_pkg::TIME_W'(r_low[NS]);

endmodule

/* rtl/ptpc_back.sv */
// Back end: scaling pipeline, clock state update and the result register.
// Depends on ptpc_pkg, ptpc_scale and the result interface in ptpc_intf.sv.
`timescale 1ns / 1ps

module ptpc_back #(
    parameter int PPB_FRACTION_BITS = ptpc_pkg::PPB_FRACTION_BITS_DEF,
    parameter int ELAPSED_WIDTH     = ptpc_pkg::ELAPSED_WIDTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    input  ptpc_pkg::t_entry                      i_entry,
    input  logic signed [ptpc_pkg::FREQ_W-1:0]    i_base_drift,
    output logic                                  o_pop,
    ptpc_out_if.source                            o_res
);

    localparam int TW = ptpc_pkg::TIME_W;

    logic                              adv;
    logic                              s_valid;
    ptpc_pkg::t_job                    s_job;
    logic [TW-1:0]                     s_amount;
    logic                              r_out_valid;
    logic [TW-1:0]                     r_time;
    logic [TW-1:0]                     r_ticks;
    logic [TW-1:0]                     r_total;
    logic signed [ptpc_pkg::EFF_W-1:0] r_eff;
    logic [TW-1:0]                     n_time;
    logic [TW-1:0]                     n_ticks;
    logic [TW-1:0]                     n_total;
    logic signed [TW+1:0]              step;

    // The whole pipeline moves whenever the result register is free or being taken.
    assign adv   = !r_out_valid || o_res.ready;
    assign o_pop = adv && i_valid;

    ptpc_scale #(
        .PPB_FRACTION_BITS (PPB_FRACTION_BITS),
        .ELAPSED_WIDTH     (ELAPSED_WIDTH)
    ) u_scale (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (adv),
        .i_valid      (i_valid),
        .i_entry      (i_entry),
        .i_base_drift (i_base_drift),
        .o_valid      (s_valid),
        .o_job        (s_job),
        .o_amount     (s_amount)
    );

    // Time step with a floor at zero; 66 bits hold every sum exactly.
    assign step = $signed({2'b00, r_time})
                + $signed({{(TW + 2 - ptpc_pkg::OFFSET_W){s_job.offset[ptpc_pkg::OFFSET_W-1]}},
                           s_job.offset});

    // Next clock state for the job leaving the pipeline.
    always_comb begin
        n_time  = r_time;
        n_ticks = r_ticks;
        n_total = r_total;
        unique case (s_job.op)
            ptpc_pkg::OP_TICK: begin
                n_time  = r_time + s_amount;
                n_ticks = r_ticks + 1'b1;
            end
            ptpc_pkg::OP_STEP: begin
                n_time  = step[TW+1] ? '0 : step[TW-1:0];
                n_total = r_total
                        + {{(TW - ptpc_pkg::OFFSET_W){s_job.offset[ptpc_pkg::OFFSET_W-1]}},
                           s_job.offset};
            end
            ptpc_pkg::OP_CLEAR: begin
                n_time  = '0;
                n_ticks = '0;
                n_total = '0;
            end
            ptpc_pkg::OP_HOLD, ptpc_pkg::OP_SLEW: begin
                n_time = r_time;
            end
            default: begin
                n_time = r_time;
            end
        endcase
    end

    // Clock state doubles as the result payload.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_time      <= '0;
            r_ticks     <= '0;
            r_total     <= '0;
            r_eff       <= '0;
        end else if (adv) begin
            r_out_valid <= s_valid;
            if (s_valid) begin
                r_time  <= n_time;
                r_ticks <= n_ticks;
                r_total <= n_total;
                r_eff   <= s_job.eff;
            end
        end
    end

    assign o_res.valid               = r_out_valid;
    assign o_res.time_ns             = r_time;
    assign o_res.ticks_seen          = r_ticks;
    assign o_res.total_offset_ns     = r_total;
    assign o_res.effective_drift_q16 = r_eff;

endmodule

/* rtl/ptpc_checker.sv */
// Port-level checks of the precision time clock block, bound to its top level.
// Depends on ptpc_pkg for widths and on ptp_clock_with_drift_adjust as the bind target.
`timescale 1ns / 1ps

module ptpc_checker (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_res_valid,
    input  logic                                   i_res_ready,
    input  logic [ptpc_pkg::TIME_W-1:0]            i_time_ns,
    input  logic [ptpc_pkg::TIME_W-1:0]            i_ticks_seen,
    input  logic [ptpc_pkg::TIME_W-1:0]            i_total_offset_ns,
    input  logic [ptpc_pkg::EFF_W-1:0]             i_effective_drift_q16
);

    logic res_acc;

    assign res_acc = i_res_valid && i_res_ready;

    // A reset leaves no result pending.
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid right after reset");

    // A stalled result holds its payload.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_time_ns)
            && $stable(i_ticks_seen) && $stable(i_total_offset_ns)
            && $stable(i_effective_drift_q16))
        else $error("stalled result changed");

    // Consecutive results count ticks by at most one, or restart from zero.
    a_ticks_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_acc && $past(res_acc) |-> i_ticks_seen == $past(i_ticks_seen)
            || i_ticks_seen == $past(i_ticks_seen) + 64'd1 || i_ticks_seen == '0)
        else $error("tick count jumped");

    // A tick moves neither the offset total nor the effective drift.
    a_tick_keeps_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_acc && $past(res_acc) && i_ticks_seen != '0
            && i_ticks_seen == $past(i_ticks_seen) + 64'd1
            |-> i_total_offset_ns == $past(i_total_offset_ns)
            && i_effective_drift_q16 == $past(i_effective_drift_q16))
        else $error("tick changed offset total or drift");

endmodule

bind ptp_clock_with_drift_adjust ptpc_checker u_ptpc_checker (
    .i_clk                 (i_clk),
    .i_rst_n               (i_rst_n),
    .i_res_valid           (o_res.valid),
    .i_res_ready           (o_res.ready),
    .i_time_ns             (o_res.time_ns),
    .i_ticks_seen          (o_res.ticks_seen),
    .i_total_offset_ns     (o_res.total_offset_ns),
    .i_effective_drift_q16 (o_res.effective_drift_q16)
);

/* tb/ptp_clock_with_drift_adjust_test.sv */
// Self-checking testbench for the precision time clock with drift adjustment.
// Depends on ptpc_pkg, the channel interfaces in ptpc_intf.sv and the top-level RTL.
`timescale 1ns / 1ps

module ptp_clock_with_drift_adjust_test;

    // Nominal scale: one billion in Q.16 parts per billion.
    localparam logic [63:0] SCALE_ONE =
        64'd1000000000 * (64'd1 << ptpc_pkg::PPB_FRACTION_BITS_DEF);
    localparam logic signed [ptpc_pkg::OFFSET_W-1:0] OFS_MAX =
        {1'b0, {(ptpc_pkg::OFFSET_W-1){1'b1}}};
    localparam logic signed [ptpc_pkg::OFFSET_W-1:0] OFS_MIN =
        {1'b1, {(ptpc_pkg::OFFSET_W-1){1'b0}}};
    localparam int LONG_HOLD   = 60;
    localparam int QUIET_LIMIT = 3000;
    localparam int DRAIN_SLACK = 40;

    typedef struct packed {
        logic [ptpc_pkg::MODE_W-1:0]          mode;
        logic [ptpc_pkg::TICK_NS_W-1:0]       tick_ns;
        logic signed [ptpc_pkg::OFFSET_W-1:0] step_ns;
        logic signed [ptpc_pkg::FREQ_W-1:0]   freq_step_q16;
    } t_item;

    typedef struct packed {
        logic [ptpc_pkg::TIME_W-1:0]        time_ns;
        logic [ptpc_pkg::TIME_W-1:0]        ticks_seen;
        logic signed [ptpc_pkg::TIME_W-1:0] total_offset_ns;
        logic signed [ptpc_pkg::EFF_W-1:0]  eff;
    } t_reading;

    // Shadow copy of the clock state that predicts the reading of every operation.
    class ptp_clock_shadow;
        bit                                 enabled;
        logic signed [ptpc_pkg::FREQ_W-1:0] base_drift;
        logic [ptpc_pkg::TIME_W-1:0]        counter;
        logic [ptpc_pkg::TIME_W-1:0]        tick_total;
        logic [ptpc_pkg::TIME_W-1:0]        offset_total;
        logic signed [ptpc_pkg::FREQ_W-1:0] freq_corr;
        t_reading                           readings_due[$];
        int                                 mismatches;
        int                                 readings_checked;
        int                                 mode_count[4];

        function new();
            enabled = 1'b1;
            base_drift = '0;
            mismatches = 0;
            readings_checked = 0;
            clear_state();
        endfunction

        function void clear_state();
            counter = '0;
            tick_total = '0;
            offset_total = '0;
            freq_corr = '0;
        endfunction

        function void set_reg(logic [ptpc_pkg::CFG_INDEX_W-1:0] idx,
                              logic [ptpc_pkg::CFG_DATA_W-1:0] data);
            if (idx == ptpc_pkg::CFG_ENABLED) begin
                enabled = data[0];
            end else begin
                base_drift = data;
            end
        endfunction

        function logic signed [ptpc_pkg::EFF_W-1:0] effective_drift();
            return {base_drift[ptpc_pkg::FREQ_W-1], base_drift}
                 + {freq_corr[ptpc_pkg::FREQ_W-1], freq_corr};
        endfunction

        // Applies one accepted operation and queues the reading it must produce.
        function void apply_item(t_item it);
            logic signed [63:0]            scale;
            logic [127:0]                  product;
            logic [127:0]                  amount;
            logic [ptpc_pkg::TIME_W-1:0]   ofs_wide;
            logic [ptpc_pkg::TIME_W-1:0]   magnitude;
            logic [ptpc_pkg::FREQ_W:0]     sum;
            t_reading                      r;
            mode_count[it.mode]++;
            ofs_wide = {{(ptpc_pkg::TIME_W-ptpc_pkg::OFFSET_W){it.step_ns[ptpc_pkg::OFFSET_W-1]}},
                        it.step_ns};
            if (it.mode == ptpc_pkg::MODE_RESET) begin
                clear_state();
            end else if (enabled) begin
                case (it.mode)
                    ptpc_pkg::MODE_TICK: begin
                        // A scale at or below zero adds nothing but still counts the tick.
                        scale = $signed(SCALE_ONE) + effective_drift();
                        if (scale > 0) begin
                            product = {96'd0, it.tick_ns} * {64'd0, scale};
                            amount = product / {64'd0, SCALE_ONE};
                            counter = counter + amount[ptpc_pkg::TIME_W-1:0];
                        end
                        tick_total = tick_total + 1;
                    end
                    ptpc_pkg::MODE_ADJ_TIME: begin
                        // The counter stops at zero; the running total takes the full step.
                        if (!it.step_ns[ptpc_pkg::OFFSET_W-1]) begin
                            counter = counter + ofs_wide;
                        end else begin
                            magnitude = -ofs_wide;
                            counter = (magnitude > counter) ? '0 : counter - magnitude;
                        end
                        offset_total = offset_total + ofs_wide;
                    end
                    ptpc_pkg::MODE_ADJ_FREQ: begin
                        // Saturate the correction at either end of its range.
                        sum = {freq_corr[ptpc_pkg::FREQ_W-1], freq_corr}
                            + {it.freq_step_q16[ptpc_pkg::FREQ_W-1], it.freq_step_q16};
                        case (sum[ptpc_pkg::FREQ_W:ptpc_pkg::FREQ_W-1])
                            2'b01:   freq_corr = ptpc_pkg::FREQ_MAX;
                            2'b10:   freq_corr = ptpc_pkg::FREQ_MIN;
                            default: freq_corr = sum[ptpc_pkg::FREQ_W-1:0];
                        endcase
                    end
                    default: ;
                endcase
            end
            r.time_ns = counter;
            r.ticks_seen = tick_total;
            r.total_offset_ns = offset_total;
            r.eff = effective_drift();
            readings_due.push_back(r);
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                $error("%s mismatch: expected %0h, actual %0h", name, want, got);
                mismatches++;
            end
        endfunction

        // Compares a received reading against the oldest one still due.
        function void check_reading(t_reading got);
            t_reading want;
            if (readings_due.size() == 0) begin
                $error("result with nothing expected: time_ns %0h", got.time_ns);
                mismatches++;
                return;
            end
            want = readings_due.pop_front();
            readings_checked++;
            compare_field("time_ns", want.time_ns, got.time_ns);
            compare_field("ticks_seen", want.ticks_seen, got.ticks_seen);
            compare_field("total_offset_ns", want.total_offset_ns, got.total_offset_ns);
            compare_field("effective_drift_q16", want.eff, got.eff);
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    ptpc_in_if  item_ch ();
    ptpc_out_if res_ch ();
    ptpc_cfg_if cfg_ch ();

    ptp_clock_with_drift_adjust u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_ch),
        .i_cfg   (cfg_ch),
        .o_res   (res_ch)
    );

    ptp_clock_shadow shadow;
    int src_idle_pct;
    int sink_idle_pct;
    bit hold_req;
    int reg_writes;
    int quiet_cycles;

    always #1 i_clk = ~i_clk;

    // Observe every transaction on the rising edge and keep the watchdog.
    always @(posedge i_clk) begin
        t_reading got;
        t_item    seen;
        bit       moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (cfg_ch.valid && cfg_ch.ready) begin
                shadow.set_reg(cfg_ch.index, cfg_ch.data);
                reg_writes++;
                moved = 1'b1;
            end
            if (res_ch.valid && res_ch.ready) begin
                got.time_ns = res_ch.time_ns;
                got.ticks_seen = res_ch.ticks_seen;
                got.total_offset_ns = res_ch.total_offset_ns;
                got.eff = res_ch.effective_drift_q16;
                shadow.check_reading(got);
                moved = 1'b1;
            end
            if (item_ch.valid && item_ch.ready) begin
                seen.mode = item_ch.mode;
                seen.tick_ns = item_ch.tick_ns;
                seen.step_ns = item_ch.step_ns;
                seen.freq_step_q16 = item_ch.freq_step_q16;
                shadow.apply_item(seen);
                moved = 1'b1;
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Result side: random stalls, plus one long hold-off when requested.
    initial begin
        int n;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                res_ch.ready = 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                res_ch.ready = 1'b1;
            end else if ($urandom_range(0, 99) < sink_idle_pct) begin
                n = $urandom_range(1, 9);
                res_ch.ready = 1'b0;
                repeat (n) @(negedge i_clk);
                res_ch.ready = 1'b1;
            end else begin
                res_ch.ready = 1'b1;
            end
        end
    end

    // Offers one operation, possibly after an idle burst, and waits for its transaction.
    task automatic send_item(logic [ptpc_pkg::MODE_W-1:0] mode,
                             logic [ptpc_pkg::TICK_NS_W-1:0] span,
                             logic signed [ptpc_pkg::OFFSET_W-1:0] ofs,
                             logic signed [ptpc_pkg::FREQ_W-1:0] fstep);
        int gap;
        if ($urandom_range(0, 99) < src_idle_pct) begin
            gap = $urandom_range(1, 9);
            @(negedge i_clk);
            item_ch.valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        item_ch.valid = 1'b1;
        item_ch.mode = mode;
        item_ch.tick_ns = span;
        item_ch.step_ns = ofs;
        item_ch.freq_step_q16 = fstep;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
    endtask

    // Stops offering and waits until every expected reading has arrived.
    task automatic drain_results();
        @(negedge i_clk);
        item_ch.valid = 1'b0;
        while (shadow.readings_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic program_reg(logic [ptpc_pkg::CFG_INDEX_W-1:0] idx,
                               logic [ptpc_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data = data;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    // Mostly small steps and ticks, with full-range values mixed in.
    function automatic t_item random_item();
        t_item it;
        int    pick;
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            it.mode = ptpc_pkg::MODE_TICK;
        end else if (pick < 72) begin
            it.mode = ptpc_pkg::MODE_ADJ_TIME;
        end else if (pick < 97) begin
            it.mode = ptpc_pkg::MODE_ADJ_FREQ;
        end else begin
            it.mode = ptpc_pkg::MODE_RESET;
        end
        if ($urandom_range(0, 9) < 7) begin
            it.tick_ns = $urandom_range(0, 2000000);
        end else begin
            it.tick_ns = $urandom;
        end
        if ($urandom_range(0, 9) < 6) begin
            it.step_ns = 48'($urandom_range(0, 2000000)) - 48'd1000000;
        end else begin
            it.step_ns = 48'({$urandom, $urandom});
        end
        if ($urandom_range(0, 9) < 8) begin
            it.freq_step_q16 = 48'($urandom_range(0, 1 << 25)) - 48'(1 << 24);
        end else begin
            it.freq_step_q16 = 48'({$urandom, $urandom});
        end
        return it;
    endfunction

    initial begin
        t_item                              it;
        int                                 phase;
        int                                 k;
        int                                 n_items;
        logic signed [ptpc_pkg::FREQ_W-1:0] drift;

        i_rst_n = 1'b0;
        item_ch.valid = 1'b0;
        item_ch.mode = ptpc_pkg::MODE_TICK;
        item_ch.tick_ns = '0;
        item_ch.step_ns = '0;
        item_ch.freq_step_q16 = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = ptpc_pkg::CFG_ENABLED;
        cfg_ch.data = '0;
        src_idle_pct = 20;
        sink_idle_pct = 20;
        hold_req = 1'b0;
        reg_writes = 0;
        quiet_cycles = 0;
        shadow = new();

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: field extremes, saturation, underflow and negative scale.
        send_item(ptpc_pkg::MODE_TICK, 32'd0, 48'sd0, 48'sd0);
        send_item(ptpc_pkg::MODE_TICK, 32'hFFFF_FFFF, 48'sd0, 48'sd0);
        send_item(ptpc_pkg::MODE_ADJ_TIME, 32'd0, OFS_MAX, 48'sd0);
        send_item(ptpc_pkg::MODE_ADJ_TIME, 32'd0, OFS_MIN, 48'sd0);
        send_item(ptpc_pkg::MODE_ADJ_TIME, 32'd0, OFS_MIN, 48'sd0);
        send_item(ptpc_pkg::MODE_ADJ_FREQ, 32'd0, 48'sd0, ptpc_pkg::FREQ_MAX);
        send_item(ptpc_pkg::MODE_ADJ_FREQ, 32'd0, 48'sd0, 48'sd1);
        send_item(ptpc_pkg::MODE_TICK, 32'hFFFF_FFFF, 48'sd0, 48'sd0);
        send_item(ptpc_pkg::MODE_ADJ_FREQ, 32'd0, 48'sd0, ptpc_pkg::FREQ_MIN);
        send_item(ptpc_pkg::MODE_ADJ_FREQ, 32'd0, 48'sd0, ptpc_pkg::FREQ_MIN);
        send_item(ptpc_pkg::MODE_TICK, 32'hFFFF_FFFF, 48'sd0, 48'sd0);
        send_item(ptpc_pkg::MODE_RESET, 32'hFFFF_FFFF, OFS_MIN, ptpc_pkg::FREQ_MAX);

        // Largest and smallest effective drift.
        drain_results();
        program_reg(ptpc_pkg::CFG_BASE_DRIFT, ptpc_pkg::FREQ_MAX);
        send_item(ptpc_pkg::MODE_ADJ_FREQ, 32'd0, 48'sd0, ptpc_pkg::FREQ_MAX);
        send_item(ptpc_pkg::MODE_TICK, 32'hFFFF_FFFF, 48'sd0, 48'sd0);
        drain_results();
        program_reg(ptpc_pkg::CFG_BASE_DRIFT, ptpc_pkg::FREQ_MIN);
        send_item(ptpc_pkg::MODE_ADJ_FREQ, 32'd0, 48'sd0, ptpc_pkg::FREQ_MIN);
        send_item(ptpc_pkg::MODE_ADJ_FREQ, 32'd0, 48'sd0, ptpc_pkg::FREQ_MIN);
        send_item(ptpc_pkg::MODE_TICK, 32'hFFFF_FFFF, 48'sd0, 48'sd0);

        // Disabled: only a clear acts, every operation still reports.
        drain_results();
        program_reg(ptpc_pkg::CFG_ENABLED, 48'd0);
        send_item(ptpc_pkg::MODE_TICK, 32'd1000, 48'sd0, 48'sd0);
        send_item(ptpc_pkg::MODE_ADJ_TIME, 32'd0, 48'sd5000, 48'sd0);
        send_item(ptpc_pkg::MODE_ADJ_FREQ, 32'd0, 48'sd0, 48'sd65536);
        send_item(ptpc_pkg::MODE_RESET, 32'd0, 48'sd0, 48'sd0);

        // Random phases, each with its own register setting and idle pattern.
        for (phase = 0; phase < 6; phase++) begin
            drain_results();
            case (phase)
                0:       drift = '0;
                1:       drift = ptpc_pkg::FREQ_MAX;
                2:       drift = ptpc_pkg::FREQ_MIN;
                4:       drift = 48'($signed($urandom));
                default: drift = 48'({$urandom, $urandom});
            endcase
            program_reg(ptpc_pkg::CFG_ENABLED, (phase == 3) ? 48'd0 : 48'd1);
            program_reg(ptpc_pkg::CFG_BASE_DRIFT, drift);
            @(posedge i_clk);
            if (phase == 5) begin
                src_idle_pct = 0;
                sink_idle_pct = 0;
            end else begin
                src_idle_pct = 15 * $urandom_range(0, 2);
                sink_idle_pct = 15 * $urandom_range(0, 2);
            end
            // The receiver holds off for a long stretch while items keep coming.
            if (phase == 1) begin
                src_idle_pct = 0;
                hold_req = 1'b1;
            end
            n_items = (phase == 3) ? 80 : 276;
            for (k = 0; k < n_items; k++) begin
                if (phase == 4 && k == n_items / 2) begin
                    drain_results();
                end
                it = random_item();
                send_item(it.mode, it.tick_ns, it.step_ns, it.freq_step_q16);
            end
        end

        drain_results();
        repeat (DRAIN_SLACK) @(posedge i_clk);
        $display("Checked %0d readings: %0d ticks, %0d time steps, %0d frequency steps, %0d clears.",
                 shadow.readings_checked, shadow.mode_count[ptpc_pkg::MODE_TICK],
                 shadow.mode_count[ptpc_pkg::MODE_ADJ_TIME],
                 shadow.mode_count[ptpc_pkg::MODE_ADJ_FREQ],
                 shadow.mode_count[ptpc_pkg::MODE_RESET]);
        $display("%0d register writes covered disabled operation and both drift extremes.",
                 reg_writes);
        if (shadow.mismatches == 0 && shadow.readings_due.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
